// ----- design/kei_pkg.sv -----
// Shared types and codes for the keyframe envelope interpolator.
// Used by kei_seg_mem and the top level; depends on nothing.
`timescale 1ns / 1ps
package kei_pkg;

	localparam int OUT_VALUES = 6;
	localparam logic [2:0] REG_LIFETIME_ADDR = 3'd0;
	localparam logic [23:0] LIFETIME_RESET = 24'd65536;
	localparam logic [16:0] FACTOR_ONE = 17'd65536;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_SEG   = 2'd1,
		CMD_START = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [15:0]        delta_time;
		logic [2:0]         channel;
		logic [2:0]         slot;
		logic signed [31:0] value;
		logic [16:0]        start_time;
		logic [16:0]        end_time;
		logic [3:0]         count;
	} item_t;

	typedef struct packed {
		logic signed [31:0] red;
		logic signed [31:0] green;
		logic signed [31:0] blue;
		logic signed [31:0] alpha;
		logic signed [31:0] turn_rate;
		logic signed [31:0] noise_power;
		logic               playing;
		logic               finished;
	} result_t;

	typedef struct packed {
		logic [31:0] target;
		logic [16:0] seg_begin;
		logic [16:0] seg_finish;
	} seg_entry_t;

endpackage

// ----- design/kei_seg_mem.sv -----
// Segment table memory: one write port, one registered read port.
// Depends on kei_pkg for the entry type.
`timescale 1ns / 1ps
module kei_seg_mem #(
	parameter int DEPTH = 48,
	parameter int ADDR_W = 6
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [ADDR_W-1:0]   wr_addr,
	input  kei_pkg::seg_entry_t wr_data,
	input  logic                rd_en,
	input  logic [ADDR_W-1:0]   rd_addr,
	output kei_pkg::seg_entry_t rd_data
);
	import kei_pkg::*;

	seg_entry_t mem_q [DEPTH];
	seg_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- design/kei_div.sv -----
// Restoring divider giving a 16-bit fraction num/den for num below den.
// One quotient bit per cycle; depends on nothing beyond the timescale.
`timescale 1ns / 1ps
module kei_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [40:0] num,
	input  logic [40:0] den,
	output logic        done,
	output logic [15:0] quot
);
	logic [41:0] rem_q;
	logic [40:0] den_q;
	logic [15:0] quot_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [41:0] shifted;
	logic        fits;

	assign shifted = {rem_q[40:0], 1'b0};
	assign fits = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 5'd16;
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quot_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? (shifted - {1'b0, den_q}) : shifted;
			quot_q <= {quot_q[14:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ----- design/keyframe_envelope_interpolator.sv -----
// Top level: command decode, per-channel state, sequencer and shared multiplier.
// Depends on kei_pkg, kei_seg_mem and kei_div.
//
//   Channel   Handshake               Payload
//   item      start in, busy out      item (item_t)
//   result    result_valid out        result (result_t)
//   config    APB psel/penable/pready paddr, pwdata, prdata
//
// Writes and other commands go from idle straight to the output state.
// A tick walks each channel in turn and, per channel with segments, reads each segment
// looked at, passes once more when the walk runs past the last segment, waits for the
// divider on an active segment short of its end and uses the shared multiplier for the
// update; the one multiplier and the one-bit-per-cycle divider set its length.
// Reset clears the control and per-channel registers and loads the lifetime with LIFETIME_RESET.
// The result is shown for one cycle and cannot be stalled.
`timescale 1ns / 1ps
module keyframe_envelope_interpolator #(
	parameter int CHANNELS = 6,
	parameter int SEGMENTS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  kei_pkg::item_t   item,
	output logic             result_valid,
	output kei_pkg::result_t result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import kei_pkg::*;

	localparam int DEPTH = CHANNELS * SEGMENTS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CHC_W = $clog2(CHANNELS + 1);
	localparam int CNT_W = $clog2(SEGMENTS + 1);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_CH   = 10'b0000000010,
		ST_RD   = 10'b0000000100,
		ST_MB   = 10'b0000001000,
		ST_ME   = 10'b0000010000,
		ST_CMP  = 10'b0000100000,
		ST_DIV  = 10'b0001000000,
		ST_MUL  = 10'b0010000000,
		ST_UPD  = 10'b0100000000,
		ST_OUT  = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [23:0] lifetime_q;
	logic [24:0] elapsed_q;
	logic play_q;
	logic fin_q;
	logic [15:0] delta_q;
	logic [CNT_W-1:0] count_q [CHANNELS];
	logic [31:0] from_q [CHANNELS];
	logic [31:0] cur_q [CHANNELS];
	logic [CHC_W-1:0] ch_q;
	logic [CNT_W-1:0] seg_q;
	logic [40:0] b_q;
	logic [16:0] factor_q;
	logic signed [51:0] prod_q;

	logic accept;
	logic cfg_wr;
	logic [CH_W-1:0] chi;
	logic [CH_W-1:0] in_chi;
	logic in_ch_ok;
	logic [CNT_W-1:0] count_sat;
	logic mem_wr;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	seg_entry_t wr_data;
	seg_entry_t rd_data;
	logic [40:0] now;
	logic [40:0] e_val;
	logic [40:0] den;
	logic [40:0] num;
	logic div_go;
	logic div_done;
	logic [15:0] div_quot;
	logic signed [33:0] mul_a;
	logic signed [17:0] mul_b;
	logic [31:0] val_w [8];

	assign accept = start && !busy;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_LIFETIME_ADDR);
	assign pready = 1'b1;
	assign prdata = (paddr == REG_LIFETIME_ADDR) ? {8'd0, lifetime_q} : 32'd0;
	assign busy = (state_q != ST_IDLE);
	assign result_valid = (state_q == ST_OUT);

	assign chi = ch_q[CH_W-1:0];
	assign in_chi = item.channel[CH_W-1:0];
	assign in_ch_ok = (int'(item.channel) < CHANNELS);
	assign count_sat = (int'(item.count) > SEGMENTS) ? CNT_W'(SEGMENTS) : CNT_W'(item.count);

	assign mem_wr = accept && (item.cmd == CMD_SEG) && in_ch_ok
		&& (int'(item.slot) < SEGMENTS);
	assign wr_addr = ADDR_W'(int'(item.channel) * SEGMENTS + int'(item.slot));
	assign rd_addr = ADDR_W'(int'(ch_q) * SEGMENTS + int'(seg_q));
	assign wr_data = '{target: item.value, seg_begin: item.start_time,
		seg_finish: item.end_time};

	kei_seg_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_mem (
		.clk(clk),
		.wr_en(mem_wr),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en((state_q == ST_RD) && (seg_q != count_q[chi])),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign now = {elapsed_q, 16'd0};
	assign e_val = prod_q[40:0];
	assign den = e_val - b_q;
	assign num = now - b_q;
	assign div_go = (state_q == ST_CMP) && !(now < b_q) && !(now > e_val)
		&& (num != den);

	kei_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.go(div_go),
		.num(num),
		.den(den),
		.done(div_done),
		.quot(div_quot)
	);

	always_comb begin
		mul_a = {10'd0, lifetime_q};
		mul_b = {1'b0, rd_data.seg_begin};
		case (state_q)
			ST_ME: begin
				mul_b = {1'b0, rd_data.seg_finish};
			end
			ST_MUL: begin
				mul_a = {{2{rd_data.target[31]}}, rd_data.target}
					- {{2{from_q[chi][31]}}, from_q[chi]};
				mul_b = {1'b0, factor_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (state_q == ST_ME) begin
			b_q <= prod_q[40:0];
		end
		if (state_q == ST_CMP) begin
			factor_q <= FACTOR_ONE;
		end else if (div_done) begin
			factor_q <= {1'b0, div_quot};
		end
		if (accept) begin
			delta_q <= item.delta_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lifetime_q <= LIFETIME_RESET;
			elapsed_q <= '0;
			play_q <= 1'b0;
			fin_q <= 1'b0;
			ch_q <= '0;
			seg_q <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				count_q[c] <= '0;
				from_q[c] <= '0;
				cur_q[c] <= '0;
			end
		end else begin
			if (cfg_wr) begin
				lifetime_q <= pwdata[23:0];
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fin_q <= 1'b0;
						state_q <= ST_OUT;
						case (item.cmd)
							CMD_TICK: begin
								if (play_q) begin
									if (elapsed_q >= {1'b0, lifetime_q}) begin
										play_q <= 1'b0;
										elapsed_q <= '0;
										fin_q <= 1'b1;
									end else begin
										ch_q <= '0;
										state_q <= ST_CH;
									end
								end
							end
							CMD_START: begin
								if (in_ch_ok) begin
									from_q[in_chi] <= item.value;
									count_q[in_chi] <= count_sat;
									if (item.count != 4'd0) begin
										play_q <= 1'b1;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_CH: begin
					seg_q <= '0;
					if (ch_q == CHC_W'(CHANNELS)) begin
						elapsed_q <= elapsed_q + {9'd0, delta_q};
						state_q <= ST_OUT;
					end else if (count_q[chi] != '0) begin
						state_q <= ST_RD;
					end else begin
						ch_q <= ch_q + CHC_W'(1);
					end
				end
				ST_RD: begin
					if (seg_q == count_q[chi]) begin
						ch_q <= ch_q + CHC_W'(1);
						state_q <= ST_CH;
					end else begin
						state_q <= ST_MB;
					end
				end
				ST_MB: begin
					state_q <= ST_ME;
				end
				ST_ME: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (now < b_q) begin
						ch_q <= ch_q + CHC_W'(1);
						state_q <= ST_CH;
					end else if (now > e_val) begin
						from_q[chi] <= rd_data.target;
						seg_q <= seg_q + CNT_W'(1);
						state_q <= ST_RD;
					end else if (num == den) begin
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					cur_q[chi] <= from_q[chi] + prod_q[47:16];
					ch_q <= ch_q + CHC_W'(1);
					state_q <= ST_CH;
				end
				ST_OUT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			val_w[j] = '0;
		end
		for (int c = 0; c < CHANNELS; c++) begin
			val_w[c] = cur_q[c];
		end
	end

	assign result = '{red: val_w[0], green: val_w[1], blue: val_w[2], alpha: val_w[3],
		turn_rate: val_w[4], noise_power: val_w[5], playing: play_q, finished: fin_q};

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("Accepted transfer did not make the block busy.");
	a_fin_stops: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.finished |-> !result.playing)
		else $error("Finished result still reports playing.");
	a_out_once: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("Result strobe held for more than one cycle.");
	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("Divider finished outside its wait state.");

endmodule
